// File: rtl/core/clm_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants of the cpu idle load meter
package clm_pkg;

   localparam int IDLE_W          = 32;
   localparam int FULL_W          = 36;
   localparam int PCT_W           = 7;
   localparam int Q15_W           = 15;
   localparam int FILL_OUT_W      = 5;
   localparam int DEFAULT_ENTRIES = 16;
   localparam int QUO_W           = Q15_W + 1;
   localparam int NUM_W           = FULL_W + Q15_W;
   localparam int STEP_W          = 5;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [STEP_W-1:0] PCT_STEPS = STEP_W'(PCT_W);
   localparam logic [STEP_W-1:0] Q15_STEPS = STEP_W'(QUO_W);
   localparam logic [Q15_W-1:0]  Q15_MAX   = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_DIV,
      ST_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      OP_WIN_PCT,
      OP_WIN_Q15,
      OP_LAT_PCT,
      OP_LAT_Q15
   } util_op_type;

   typedef struct packed {
      logic              valid;
      logic [IDLE_W-1:0] delta;
   } delta_word_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [NUM_W-1:0]  den_sh;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quo;
   } div_stat_type;

   typedef struct packed {
      logic [PCT_W-1:0]      window_percent;
      logic [Q15_W-1:0]      window_q15;
      logic [PCT_W-1:0]      latest_percent;
      logic [Q15_W-1:0]      latest_q15;
      logic [FULL_W-1:0]     window_sum;
      logic [FULL_W-1:0]     peak_scaled;
      logic [FILL_OUT_W-1:0] entries_filled;
   } result_type;

endpackage

// File: rtl/core/cpu_idle_load_meter.sv
`timescale 1ns / 1ps
// cpu idle load meter top level
//
// req channel (valid/ready): one word per measurement tick, carrying the
//   free-running idle loop counter; the block takes the wrapping delta to
//   the previous word and pushes it into a two-word queue
// rsp channel (valid/ready): exactly one result word per request word, in
//   order: window and latest utilization as percent and q15, window sum,
//   peak delta times entries and the ring fill count
// csr port: csr_wr_en writes the 36 bit full scale idle count, no wait;
//   write it only while the block is idle
// sequence: the back end takes one word at a time (queue pop, ring read and
//   update, four divisions of 7, 16, 7 and 16 steps on the shared bit-serial
//   divider, each skipped when no utilization applies, then a result load)
// reset: ring, sum, peak, fill count, last sample and full scale go to
//   zero at once; the ring memory needs no clearing pass since the fill
//   count masks slots that were never written
// stall: a blocked rsp holds its word in the output register; the back end
//   then waits, the queue fills and req_ready drops after two more words
module cpu_idle_load_meter #(
   parameter int ENTRIES = clm_pkg::DEFAULT_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,

   // configuration
   input  logic                           csr_wr_en,
   input  logic [clm_pkg::FULL_W-1:0]     csr_wr_data,

   // request words
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [clm_pkg::IDLE_W-1:0]     req_idle_count,

   // result words
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [clm_pkg::PCT_W-1:0]      rsp_window_percent,
   output logic [clm_pkg::Q15_W-1:0]      rsp_window_q15,
   output logic [clm_pkg::PCT_W-1:0]      rsp_latest_percent,
   output logic [clm_pkg::Q15_W-1:0]      rsp_latest_q15,
   output logic [clm_pkg::FULL_W-1:0]     rsp_window_sum,
   output logic [clm_pkg::FULL_W-1:0]     rsp_peak_scaled,
   output logic [clm_pkg::FILL_OUT_W-1:0] rsp_entries_filled
);

   // full scale register
   logic [clm_pkg::FULL_W-1:0] full_scale_ff, full_scale_in;

   // front to queue to back
   clm_pkg::delta_word_type push;
   clm_pkg::delta_word_type head;
   logic                    queue_full;
   logic                    pop;

   // back to divider
   clm_pkg::div_req_type    div_req;
   clm_pkg::div_stat_type   div_stat;

   clm_pkg::result_type     rsp;

   assign full_scale_in = csr_wr_en ? csr_wr_data : full_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= '0;
      end else begin
         full_scale_ff <= full_scale_in;
      end
   end

   // delta forming and request handshake
   clm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_idle_count (req_idle_count),
      .queue_full     (queue_full),
      .push           (push)
   );

   // decouples the two sides
   clm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   // ring, sums and utilization sequencing
   clm_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .full_scale (full_scale_ff),
      .head       (head),
      .pop        (pop),
      .div_req    (div_req),
      .div_stat   (div_stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // shared bit-serial divider
   clm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   assign rsp_window_percent = rsp.window_percent;
   assign rsp_window_q15     = rsp.window_q15;
   assign rsp_latest_percent = rsp.latest_percent;
   assign rsp_latest_q15     = rsp.latest_q15;
   assign rsp_window_sum     = rsp.window_sum;
   assign rsp_peak_scaled    = rsp.peak_scaled;
   assign rsp_entries_filled = rsp.entries_filled;

endmodule

// File: rtl/core/clm_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module clm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/clm_queue.sv
`timescale 1ns / 1ps
// short queue of idle deltas between front and back
module clm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  clm_pkg::delta_word_type push,
   output logic                    full,
   input  logic                    pop,
   output clm_pkg::delta_word_type head
);

   localparam int PTR_W = $clog2(clm_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(clm_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(clm_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(clm_pkg::QUEUE_DEPTH);

   logic [clm_pkg::IDLE_W-1:0] entry_ff [clm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   always_comb begin
      do_push   = push.valid && (count_ff != CNT_MAX);
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.delta;
      end
   end

   assign full       = (count_ff == CNT_MAX);
   assign head.valid = (count_ff != '0);
   assign head.delta = entry_ff[rd_ptr_ff];

endmodule

// File: rtl/core/clm_front.sv
`timescale 1ns / 1ps
// input side: takes idle counter words and forms wrapping deltas
module clm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [clm_pkg::IDLE_W-1:0] req_idle_count,
   input  logic                       queue_full,
   output clm_pkg::delta_word_type    push
);

   logic [clm_pkg::IDLE_W-1:0] last_idle_ff, last_idle_in;
   logic                       accept;

   always_comb begin
      req_ready    = !queue_full;
      accept       = req_valid && req_ready;
      last_idle_in = accept ? req_idle_count : last_idle_ff;
      push.valid   = accept;
      // modulo 2^32 difference, so a counter wrap is handled for free
      push.delta   = req_idle_count - last_idle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idle_ff <= '0;
      end else begin
         last_idle_ff <= last_idle_in;
      end
   end

endmodule

// File: rtl/core/clm_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
module clm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  clm_pkg::div_req_type req,
   output clm_pkg::div_stat_type stat
);

   logic [clm_pkg::NUM_W-1:0]  rem_ff, rem_in;
   logic [clm_pkg::NUM_W-1:0]  dsh_ff, dsh_in;
   logic [clm_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [clm_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       fits;

   always_comb begin
      fits    = (rem_ff >= dsh_ff);
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num;
         dsh_in  = req.den_sh;
         quo_in  = '0;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[clm_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == clm_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quo  = quo_ff;

endmodule

// File: rtl/core/clm_back.sv
`timescale 1ns / 1ps
// back side: delta ring, window sum, peak, utilization sequencer, result register
module clm_back #(
   parameter int ENTRIES = clm_pkg::DEFAULT_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [clm_pkg::FULL_W-1:0] full_scale,
   input  clm_pkg::delta_word_type    head,
   output logic                       pop,
   output clm_pkg::div_req_type       div_req,
   input  clm_pkg::div_stat_type      div_stat,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output clm_pkg::result_type        rsp
);

   localparam int SLOT_W  = $clog2(ENTRIES);
   localparam int FILL_W  = $clog2(ENTRIES + 1);
   localparam int SCALE_W = $clog2(ENTRIES + 1);
   localparam int SUM_W   = clm_pkg::IDLE_W + SCALE_W;
   localparam int CMP_W   = (SUM_W > clm_pkg::FULL_W) ? SUM_W : clm_pkg::FULL_W;
   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(ENTRIES - 1);
   localparam logic [FILL_W-1:0]  FILL_MAX  = FILL_W'(ENTRIES);
   localparam logic [SCALE_W-1:0] SCALE     = SCALE_W'(ENTRIES);

   clm_pkg::back_state_type    state_ff, state_in;
   clm_pkg::util_op_type       op_ff, op_in, op_next;
   logic [clm_pkg::IDLE_W-1:0] delta_ff, delta_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [clm_pkg::IDLE_W-1:0] peak_ff, peak_in;
   logic [SUM_W-1:0]           latest_ff, latest_in;
   logic [clm_pkg::PCT_W-1:0]  win_pct_ff, win_pct_in;
   logic [clm_pkg::Q15_W-1:0]  win_q15_ff, win_q15_in;
   logic [clm_pkg::PCT_W-1:0]  lat_pct_ff, lat_pct_in;
   logic [clm_pkg::Q15_W-1:0]  lat_q15_ff, lat_q15_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   clm_pkg::result_type        rsp_ff, rsp_in;

   logic                       ram_rd_en;
   logic                       ram_wr_en;
   logic [clm_pkg::IDLE_W-1:0] ram_rd_data;
   logic [clm_pkg::IDLE_W-1:0] old_delta;
   logic [SUM_W-1:0]           sum_next;

   logic                       is_q15;
   logic                       is_latest;
   logic [CMP_W-1:0]           x_cmp;
   logic [CMP_W-1:0]           full_cmp;
   logic [CMP_W-1:0]           rest_wide;
   logic [clm_pkg::FULL_W-1:0] rest;
   logic [clm_pkg::NUM_W-1:0]  rest_num;
   logic                       no_util;
   logic                       store;
   logic [clm_pkg::QUO_W-1:0]  util_val;
   logic [clm_pkg::PCT_W-1:0]  pct_val;
   logic [clm_pkg::Q15_W-1:0]  q15_val;
   logic                       load_out;

   logic [SUM_W+clm_pkg::FULL_W-1:0]      sum_pad;
   logic [SUM_W+clm_pkg::FULL_W-1:0]      peak_pad;
   logic [SUM_W-1:0]                      peak_scaled;
   logic [FILL_W+clm_pkg::FILL_OUT_W-1:0] fill_pad;

   clm_ram #(
      .WIDTH (clm_pkg::IDLE_W),
      .DEPTH (ENTRIES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (delta_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // operand selection and utilization arithmetic
   always_comb begin
      // slots not yet written since reset count as zero; before the ring is
      // full the write slot always points at such a slot
      old_delta = (fill_ff == FILL_MAX) ? ram_rd_data : '0;
      sum_next  = sum_ff - SUM_W'(old_delta) + SUM_W'(delta_ff);

      is_q15    = (op_ff == clm_pkg::OP_WIN_Q15) || (op_ff == clm_pkg::OP_LAT_Q15);
      is_latest = (op_ff == clm_pkg::OP_LAT_PCT) || (op_ff == clm_pkg::OP_LAT_Q15);
      x_cmp     = is_latest ? CMP_W'(latest_ff) : CMP_W'(sum_ff);
      full_cmp  = CMP_W'(full_scale);
      no_util   = (full_scale == '0) || (x_cmp > full_cmp);
      rest_wide = full_cmp - x_cmp;
      rest      = rest_wide[clm_pkg::FULL_W-1:0];
      rest_num  = clm_pkg::NUM_W'(rest);

      // rest * 100 as shifts; rest * 32768 as a shift
      div_req.num = is_q15 ? (rest_num << clm_pkg::Q15_W)
                           : (rest_num << 6) + (rest_num << 5) + (rest_num << 2);
      div_req.den_sh = is_q15 ? (clm_pkg::NUM_W'(full_scale) << (clm_pkg::QUO_W - 1))
                              : (clm_pkg::NUM_W'(full_scale) << (clm_pkg::PCT_W - 1));
      div_req.steps  = is_q15 ? clm_pkg::Q15_STEPS : clm_pkg::PCT_STEPS;
      div_req.start  = (state_ff == clm_pkg::ST_START) && !no_util;

      util_val = (state_ff == clm_pkg::ST_DIV) ? div_stat.quo : '0;
      pct_val  = util_val[clm_pkg::PCT_W-1:0];
      // an idle ratio of one gives 32768, clipped to the top of q15
      q15_val  = util_val[clm_pkg::QUO_W-1] ? clm_pkg::Q15_MAX
                                             : util_val[clm_pkg::Q15_W-1:0];
   end

   always_comb begin
      unique case (op_ff)
         clm_pkg::OP_WIN_PCT: op_next = clm_pkg::OP_WIN_Q15;
         clm_pkg::OP_WIN_Q15: op_next = clm_pkg::OP_LAT_PCT;
         clm_pkg::OP_LAT_PCT: op_next = clm_pkg::OP_LAT_Q15;
         clm_pkg::OP_LAT_Q15: op_next = clm_pkg::OP_WIN_PCT;
         default:             op_next = clm_pkg::OP_WIN_PCT;
      endcase
   end

   // saturated and truncated result fields
   always_comb begin
      peak_scaled = SUM_W'(peak_ff) * SUM_W'(SCALE);
      sum_pad     = {{clm_pkg::FULL_W{1'b0}}, sum_ff};
      peak_pad    = {{clm_pkg::FULL_W{1'b0}}, peak_scaled};
      fill_pad    = {{clm_pkg::FILL_OUT_W{1'b0}}, fill_ff};

      rsp_in.window_percent = win_pct_ff;
      rsp_in.window_q15     = win_q15_ff;
      rsp_in.latest_percent = lat_pct_ff;
      rsp_in.latest_q15     = lat_q15_ff;
      rsp_in.window_sum     = (|sum_pad[SUM_W+clm_pkg::FULL_W-1:clm_pkg::FULL_W])
                              ? '1 : sum_pad[clm_pkg::FULL_W-1:0];
      rsp_in.peak_scaled    = (|peak_pad[SUM_W+clm_pkg::FULL_W-1:clm_pkg::FULL_W])
                              ? '1 : peak_pad[clm_pkg::FULL_W-1:0];
      rsp_in.entries_filled = fill_pad[clm_pkg::FILL_OUT_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      delta_in   = delta_ff;
      slot_in    = slot_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      peak_in    = peak_ff;
      latest_in  = latest_ff;
      win_pct_in = win_pct_ff;
      win_q15_in = win_q15_ff;
      lat_pct_in = lat_pct_ff;
      lat_q15_in = lat_q15_ff;
      pop        = 1'b0;
      ram_rd_en  = 1'b0;
      ram_wr_en  = 1'b0;
      store      = 1'b0;
      load_out   = (state_ff == clm_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);

      unique case (state_ff)
         clm_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               ram_rd_en = 1'b1;
               delta_in  = head.delta;
               state_in  = clm_pkg::ST_READ;
            end
         end
         clm_pkg::ST_READ: begin
            ram_wr_en = 1'b1;
            sum_in    = sum_next;
            slot_in   = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            fill_in   = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + 1'b1;
            peak_in   = (delta_ff > peak_ff) ? delta_ff : peak_ff;
            latest_in = SUM_W'(delta_ff) * SUM_W'(SCALE);
            op_in     = clm_pkg::OP_WIN_PCT;
            state_in  = clm_pkg::ST_START;
         end
         clm_pkg::ST_START: begin
            if (no_util) begin
               store = 1'b1;
            end else begin
               state_in = clm_pkg::ST_DIV;
            end
         end
         clm_pkg::ST_DIV: begin
            store = div_stat.done;
         end
         clm_pkg::ST_OUT: begin
            if (load_out) begin
               state_in = clm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clm_pkg::ST_IDLE;
         end
      endcase

      if (store) begin
         unique case (op_ff)
            clm_pkg::OP_WIN_PCT: win_pct_in = pct_val;
            clm_pkg::OP_WIN_Q15: win_q15_in = q15_val;
            clm_pkg::OP_LAT_PCT: lat_pct_in = pct_val;
            clm_pkg::OP_LAT_Q15: lat_q15_in = q15_val;
            default:             win_pct_in = pct_val;
         endcase
         op_in    = op_next;
         state_in = (op_ff == clm_pkg::OP_LAT_Q15) ? clm_pkg::ST_OUT : clm_pkg::ST_START;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clm_pkg::ST_IDLE;
         op_ff        <= clm_pkg::OP_WIN_PCT;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff   <= delta_in;
      latest_ff  <= latest_in;
      win_pct_ff <= win_pct_in;
      win_q15_ff <= win_q15_in;
      lat_pct_ff <= lat_pct_in;
      lat_q15_ff <= lat_q15_in;
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count beyond ring depth");

   a_slot_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != FILL_MAX) |-> (FILL_W'(slot_ff) == fill_ff))
      else $error("write slot out of step with fill count before ring is full");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == clm_pkg::ST_DIV))
      else $error("divider finished outside the divide state");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the cpu idle load meter with its own utilisation predictor
module tb_top;

   localparam int          ENTRIES     = clm_pkg::DEFAULT_ENTRIES;
   localparam logic [63:0] FULL_MAX    = 64'hF_FFFF_FFFF;
   // cycles without any handshake before the run is declared hung; a word needs
   // its full back end pass plus whatever the receiver stalls
   localparam int          QUIET_LIMIT = 4000;
   localparam int          BATCH_TICKS = 317;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [clm_pkg::FULL_W-1:0]     csr_wr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [clm_pkg::IDLE_W-1:0]     req_idle_count = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [clm_pkg::PCT_W-1:0]      rsp_window_percent;
   logic [clm_pkg::Q15_W-1:0]      rsp_window_q15;
   logic [clm_pkg::PCT_W-1:0]      rsp_latest_percent;
   logic [clm_pkg::Q15_W-1:0]      rsp_latest_q15;
   logic [clm_pkg::FULL_W-1:0]     rsp_window_sum;
   logic [clm_pkg::FULL_W-1:0]     rsp_peak_scaled;
   logic [clm_pkg::FILL_OUT_W-1:0] rsp_entries_filled;

   // predictor copy of the meter state, all zero as after reset
   logic [clm_pkg::IDLE_W-1:0]     delta_ring [ENTRIES] = '{default: '0};
   int                             ring_slot = 0;
   int                             ring_fill = 0;
   logic [clm_pkg::IDLE_W-1:0]     last_sample = '0;
   logic [63:0]                    ring_sum = '0;
   logic [clm_pkg::IDLE_W-1:0]     peak_delta = '0;
   logic [clm_pkg::FULL_W-1:0]     full_scale = '0;

   logic [clm_pkg::IDLE_W-1:0]     ticks_pending [$];
   clm_pkg::result_type            results_due [$];
   logic [clm_pkg::IDLE_W-1:0]     counter_now = '0;
   int                             send_gap_pct = 11;
   int                             take_gap_pct = 65;
   int                             mismatch_count = 0;
   clm_pkg::result_type            seen_word;
   clm_pkg::result_type            due_word;

   cpu_idle_load_meter #(
      .ENTRIES (ENTRIES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_idle_count     (req_idle_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_window_percent (rsp_window_percent),
      .rsp_window_q15     (rsp_window_q15),
      .rsp_latest_percent (rsp_latest_percent),
      .rsp_latest_q15     (rsp_latest_q15),
      .rsp_window_sum     (rsp_window_sum),
      .rsp_peak_scaled    (rsp_peak_scaled),
      .rsp_entries_filled (rsp_entries_filled)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // utilisation (full - load) / full as whole percent and saturated q15;
   // zero full scale or a load above full scale gives zero
   task automatic idle_ratio(input logic [63:0] load,
                             output logic [clm_pkg::PCT_W-1:0] pct,
                             output logic [clm_pkg::Q15_W-1:0] q15);
      logic [63:0] rest;
      logic [63:0] frac;
      if (full_scale == '0 || load > full_scale) begin
         pct = '0;
         q15 = '0;
      end else begin
         rest = full_scale - load;
         pct  = clm_pkg::PCT_W'((rest * 100) / full_scale);
         frac = (rest * 32768) / full_scale;
         // load of zero lands exactly on 32768 and saturates
         q15  = (frac > clm_pkg::Q15_MAX) ? clm_pkg::Q15_MAX : clm_pkg::Q15_W'(frac);
      end
   endtask

   // one accepted tick: wrapping delta into the ring, then the result word it causes
   task automatic advance_meter(input logic [clm_pkg::IDLE_W-1:0] sample);
      logic [clm_pkg::IDLE_W-1:0] delta;
      logic [63:0]                scaled_peak;
      clm_pkg::result_type        r;
      delta       = sample - last_sample;
      last_sample = sample;
      ring_sum    = ring_sum - 64'(delta_ring[ring_slot]) + 64'(delta);
      delta_ring[ring_slot] = delta;
      ring_slot   = (ring_slot == ENTRIES - 1) ? 0 : ring_slot + 1;
      if (ring_fill < ENTRIES)
         ring_fill++;
      if (delta > peak_delta)
         peak_delta = delta;
      idle_ratio(ring_sum, r.window_percent, r.window_q15);
      idle_ratio(64'(delta) * ENTRIES, r.latest_percent, r.latest_q15);
      scaled_peak      = 64'(peak_delta) * ENTRIES;
      r.window_sum     = (ring_sum > FULL_MAX) ? clm_pkg::FULL_W'(FULL_MAX)
                                               : clm_pkg::FULL_W'(ring_sum);
      r.peak_scaled    = (scaled_peak > FULL_MAX) ? clm_pkg::FULL_W'(FULL_MAX)
                                                  : clm_pkg::FULL_W'(scaled_peak);
      r.entries_filled = clm_pkg::FILL_OUT_W'(ring_fill);
      results_due.push_back(r);
   endtask

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns  %s: expected %0d, got %0d", $time, field, want, got);
   endtask

   // driver: presents the next queued tick when the word slot is free and the
   // random gap allows, holds the word steady while ready is low
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            advance_meter(req_idle_count);
         if (!req_valid || req_ready) begin
            if (ticks_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid      <= 1'b1;
               req_idle_count <= ticks_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and monitor: random back pressure, every accepted word checked
   // field by field against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= take_gap_pct);
         if (rsp_valid && rsp_ready) begin
            seen_word = {rsp_window_percent, rsp_window_q15, rsp_latest_percent,
                         rsp_latest_q15, rsp_window_sum, rsp_peak_scaled,
                         rsp_entries_filled};
            if (results_due.size() == 0) begin
               note_mismatch("word with nothing due, window_sum", '0, seen_word.window_sum);
            end else begin
               due_word = results_due.pop_front();
               if (seen_word.window_percent !== due_word.window_percent)
                  note_mismatch("window_percent", due_word.window_percent,
                                seen_word.window_percent);
               if (seen_word.window_q15 !== due_word.window_q15)
                  note_mismatch("window_q15", due_word.window_q15, seen_word.window_q15);
               if (seen_word.latest_percent !== due_word.latest_percent)
                  note_mismatch("latest_percent", due_word.latest_percent,
                                seen_word.latest_percent);
               if (seen_word.latest_q15 !== due_word.latest_q15)
                  note_mismatch("latest_q15", due_word.latest_q15, seen_word.latest_q15);
               if (seen_word.window_sum !== due_word.window_sum)
                  note_mismatch("window_sum", due_word.window_sum, seen_word.window_sum);
               if (seen_word.peak_scaled !== due_word.peak_scaled)
                  note_mismatch("peak_scaled", due_word.peak_scaled, seen_word.peak_scaled);
               if (seen_word.entries_filled !== due_word.entries_filled)
                  note_mismatch("entries_filled", due_word.entries_filled,
                                seen_word.entries_filled);
            end
         end
      end
   end

   // hang detection: any stretch without a handshake on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("cpu_idle_load_meter: mismatch");
      $finish;
   end

   // full scale may only change while the meter is idle
   task automatic write_full_scale(input logic [clm_pkg::FULL_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      full_scale   = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_tick(input logic [clm_pkg::IDLE_W-1:0] value);
      counter_now = value;
      ticks_pending.push_back(value);
   endtask

   // sender holds off until every word is back and the driver is empty
   task automatic drain_all();
      while (ticks_pending.size() != 0 || req_valid || results_due.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // mostly a well behaved counter stepping by up to twice the nominal idle
   // delta of one slot, with repeats, wild jumps and backward steps mixed in
   task automatic queue_ticks(input int count);
      logic [63:0] nominal;
      logic [63:0] span;
      int          pick;
      nominal = 64'(full_scale >> 4);
      repeat (count) begin
         pick = $urandom_range(99);
         span = (nominal * ($urandom_range(3, 0) + 1)) / 2 + 1;
         if (pick < 85)
            push_tick(counter_now + clm_pkg::IDLE_W'(64'($urandom) % span));
         else if (pick < 95)
            push_tick(counter_now);
         else if (pick < 98)
            push_tick($urandom);
         else
            push_tick(counter_now - $urandom_range(1000, 1));
      end
   endtask

   initial begin
      int batch;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed words against a full scale of 1000 per slot
      write_full_scale(clm_pkg::FULL_W'(16000));
      push_tick(32'd0);              // first tick: delta is the sample, empty window
      push_tick(32'd500);            // half load on the latest delta
      push_tick(32'd1500);           // latest load exactly at full scale
      push_tick(32'd2600);           // latest load just above full scale
      push_tick(32'hFFFF_FFFF);      // large step, window far above full scale
      push_tick(32'h0000_0005);      // counter wraps through zero
      push_tick(32'h8000_0000);
      push_tick(32'h7FFF_FFFF);      // wrapping delta of all ones, peak at its maximum
      push_tick(32'h7FFF_FFFF);      // no idle time at all
      for (int k = 1; k <= 12; k++)  // fills the ring, fill count saturates
         push_tick(32'h7FFF_FFFF + 32'(k * 1000));
      drain_all();
      write_full_scale('0);          // zero full scale blanks all utilisation fields
      push_tick(counter_now + 32'd400);
      push_tick(counter_now);
      drain_all();
      write_full_scale(clm_pkg::FULL_W'(FULL_MAX));
      push_tick(counter_now + 32'd12345);
      push_tick(counter_now);
      drain_all();

      // random batches, each with its own full scale and a full drain between
      for (batch = 0; batch < 6; batch++) begin
         if (batch == 2) begin
            send_gap_pct = 65;
            take_gap_pct = 11;
         end else if (batch == 4) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end
         case (batch)
            0: write_full_scale(clm_pkg::FULL_W'(16 * $urandom_range(1 << 20, 1000)));
            1: write_full_scale({4'($urandom_range(15, 0)), 32'($urandom)});
            2: write_full_scale(clm_pkg::FULL_W'(16 * $urandom_range(60, 1)));
            3: write_full_scale(clm_pkg::FULL_W'(FULL_MAX));
            4: write_full_scale({4'($urandom_range(15, 0)), 32'($urandom)});
            default: write_full_scale(clm_pkg::FULL_W'(64'(16) * $urandom));
         endcase
         queue_ticks(BATCH_TICKS);
         drain_all();
      end

      // tail: nothing further may turn up within the back end latency
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && results_due.size() == 0)
         $display("cpu_idle_load_meter: match");
      else
         $display("cpu_idle_load_meter: mismatch");
      $finish;
   end

endmodule
